>>> rtl/gradient_non_maximum_suppression_macros.svh
// Assertion macros for the gradient non-maximum suppression checker.
`ifndef GRADIENT_NON_MAXIMUM_SUPPRESSION_MACROS_SVH
`define GRADIENT_NON_MAXIMUM_SUPPRESSION_MACROS_SVH
// Property checked at every clock edge while reset is released.
`define GNMS_ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked at every clock edge, reset included.
`define GNMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/gnms_pkg.sv
// Shared types and constants of the gradient non-maximum suppression block.
package gnms_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int GRAD_W        = 11;
  localparam int MAG_W         = 15;
  localparam int CFG_W_W       = 11;
  localparam int CFG_H_W       = 12;
  localparam int CFG_DATA_W    = 12;
  localparam int ROW_W         = 13;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 16;
  localparam int TAN_W         = 34;
  localparam int FRAC_SHIFT    = 32;

  localparam logic [TAN_W-1:0] TAN_LOW_Q32  = 34'd1779033704;
  localparam logic [TAN_W-1:0] TAN_HIGH_Q32 = 34'd10368968296;

  localparam int                 RESET_WIDTH  = 640;
  localparam logic [CFG_H_W-1:0] RESET_HEIGHT = 12'd480;

  typedef enum logic [1:0] {
    DIR_HORIZ = 2'd0,
    DIR_DIAG  = 2'd1,
    DIR_VERT  = 2'd2,
    DIR_ANTI  = 2'd3
  } gnms_dir_t;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } gnms_reg_t;

  typedef struct packed {
    logic up_ok;
    logic down_ok;
    logic left_ok;
    logic right_ok;
  } gnms_bounds_t;

  typedef struct packed {
    logic [MAG_W-1:0] top;
    logic [MAG_W-1:0] mid;
    logic [MAG_W-1:0] bot;
  } gnms_col_t;

endpackage

>>> rtl/gnms_dir_bin.sv
// Gradient direction binning into four sectors.
module gnms_dir_bin
  import gnms_pkg::*;
(
  input  logic [GRAD_W-1:0] grad_x,
  input  logic [GRAD_W-1:0] grad_y,
  output gnms_dir_t         dir
);

  localparam int PROD_W = GRAD_W + TAN_W;

  logic [GRAD_W-1:0] abs_x;
  logic [GRAD_W-1:0] abs_y;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs_low;
  logic [PROD_W-1:0] rhs_high;

  assign abs_x    = grad_x[GRAD_W-1] ? (~grad_x + 1'b1) : grad_x;
  assign abs_y    = grad_y[GRAD_W-1] ? (~grad_y + 1'b1) : grad_y;
  assign lhs      = PROD_W'({abs_y, {FRAC_SHIFT{1'b0}}});
  assign rhs_low  = PROD_W'(abs_x) * PROD_W'(TAN_LOW_Q32);
  assign rhs_high = PROD_W'(abs_x) * PROD_W'(TAN_HIGH_Q32);

  always_comb begin
    if (abs_x == '0) begin
      dir = (abs_y != '0) ? DIR_VERT : DIR_HORIZ;
    end else if (abs_y == '0) begin
      dir = DIR_HORIZ;
    end else if (lhs > rhs_high) begin
      dir = DIR_VERT;
    end else if (lhs > rhs_low) begin
      dir = (grad_x[GRAD_W-1] == grad_y[GRAD_W-1]) ? DIR_DIAG : DIR_ANTI;
    end else begin
      dir = DIR_HORIZ;
    end
  end

endmodule

>>> rtl/gnms_line_buf.sv
// Line memories for the two previous magnitude rows and the previous direction row.
module gnms_line_buf
  import gnms_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  input  logic [MAG_W-1:0]             wr_mag,
  input  gnms_dir_t                    wr_dir,
  output logic [MAG_W-1:0]             rd_upper,
  output logic [MAG_W-1:0]             rd_prev,
  output gnms_dir_t                    rd_dir
);

  logic [MAG_W-1:0] prev_mem  [MAX_WIDTH];
  logic [MAG_W-1:0] upper_mem [MAX_WIDTH];
  gnms_dir_t        dir_mem   [MAX_WIDTH];

  logic [MAG_W-1:0] rd_upper_r;
  logic [MAG_W-1:0] rd_prev_r;
  gnms_dir_t        rd_dir_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_mem[wr_col]  <= wr_mag;
      upper_mem[wr_col] <= rd_prev_r;
      dir_mem[wr_col]   <= wr_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_prev_r  <= prev_mem[rd_col];
      rd_upper_r <= upper_mem[rd_col];
      rd_dir_r   <= dir_mem[rd_col];
    end
  end

  assign rd_upper = rd_upper_r;
  assign rd_prev  = rd_prev_r;
  assign rd_dir   = rd_dir_r;

endmodule

>>> rtl/gnms_window.sv
// Three-column window and the suppression compare along the binned direction.
module gnms_window
  import gnms_pkg::*;
(
  input  logic             clk,
  input  logic             shift_en,
  input  gnms_col_t        new_col,
  input  gnms_dir_t        new_dir,
  input  gnms_bounds_t     bounds,
  output logic [MAG_W-1:0] kept_mag
);

  gnms_col_t        center_r;
  gnms_col_t        left_r;
  gnms_dir_t        cdir_r;
  logic [MAG_W-1:0] nb_a;
  logic [MAG_W-1:0] nb_b;
  logic             ok_a;
  logic             ok_b;
  logic             blocked;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      left_r   <= center_r;
      center_r <= new_col;
      cdir_r   <= new_dir;
    end
  end

  always_comb begin
    case (cdir_r)
      DIR_DIAG: begin
        nb_a = left_r.top;
        ok_a = bounds.up_ok && bounds.left_ok;
        nb_b = new_col.bot;
        ok_b = bounds.down_ok && bounds.right_ok;
      end
      DIR_VERT: begin
        nb_a = center_r.top;
        ok_a = bounds.up_ok;
        nb_b = center_r.bot;
        ok_b = bounds.down_ok;
      end
      DIR_ANTI: begin
        nb_a = left_r.bot;
        ok_a = bounds.down_ok && bounds.left_ok;
        nb_b = new_col.top;
        ok_b = bounds.up_ok && bounds.right_ok;
      end
      default: begin
        nb_a = left_r.mid;
        ok_a = bounds.left_ok;
        nb_b = new_col.mid;
        ok_b = bounds.right_ok;
      end
    endcase
  end

  assign blocked  = (ok_a && (center_r.mid <= nb_a)) || (ok_b && (center_r.mid <= nb_b));
  assign kept_mag = blocked ? '0 : center_r.mid;

endmodule

>>> rtl/gradient_non_maximum_suppression.sv
// Top level of the streaming 3x3 gradient non-maximum suppression block.
//
// Channel  Direction  Handshake           Payload
// in_      slave      in_tvalid/tready    tdata: gradients, magnitude; tuser: drain flag
// out_     master     out_tvalid/tready   tdata: kept magnitude; tlast: frame end
// cfg_     write      cfg_we              cfg_index selects width or height
//
// One item is taken per clock while in_tready is high; a result leaves through the input
// and output registers after the item that completes its window, one row plus one pixel
// behind the pixel it belongs to. The input register and the output register part the two
// sides, so a waiting result stalls input only when the next item also carries a result.
// Reset is synchronous and needs no clearing pass: line memory is read only where this
// frame has written it. A configuration write restarts the frame.
module gradient_non_maximum_suppression
  import gnms_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // grad_x [10:0], grad_y [21:11], magnitude [36:22], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op [0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // kept_magnitude [14:0], zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W   = (WW > CFG_W_W) ? WW : CFG_W_W;
  localparam int RESET_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  logic [WW-1:0]      width_r;
  logic [CFG_H_W-1:0] height_r;
  logic [WW-1:0]      width_cfg;
  logic [CFG_H_W-1:0] height_cfg;
  logic [CFG_W_W-1:0] cfg_w_raw;
  logic [CFG_H_W-1:0] cfg_h_raw;

  logic [ROW_W-1:0]   in_row_r;
  logic [COL_W-1:0]   in_col_r;
  logic [ROW_W-1:0]   prev_row_r;
  logic [COL_W-1:0]   prev_col_r;
  logic [ROW_W-1:0]   height_ext;

  logic               accept;
  logic               frame_done;
  logic               step;
  logic               step_emit;
  logic               step_last;
  logic               col_wrap;
  gnms_bounds_t       bounds_nxt;

  logic               a_valid_r;
  logic               a_emit_r;
  logic               a_last_r;
  logic [GRAD_W-1:0]  a_gx_r;
  logic [GRAD_W-1:0]  a_gy_r;
  logic [MAG_W-1:0]   a_mag_r;
  logic [COL_W-1:0]   a_col_r;
  gnms_bounds_t       a_bounds_r;
  logic               a_go;
  logic               out_free;

  logic               out_valid_r;
  logic [MAG_W-1:0]   out_mag_r;
  logic               out_last_r;

  gnms_dir_t          a_dir;
  logic [MAG_W-1:0]   rd_upper;
  logic [MAG_W-1:0]   rd_prev;
  gnms_dir_t          rd_dir;
  gnms_col_t          new_col;
  logic [MAG_W-1:0]   kept_mag;

  // Configuration values, clamped to the supported range.
  assign cfg_w_raw = cfg_wdata[CFG_W_W-1:0];
  assign cfg_h_raw = cfg_wdata[CFG_H_W-1:0];

  always_comb begin
    if (cfg_w_raw < CFG_W_W'(2)) begin
      width_cfg = WW'(2);
    end else if (CMP_W'(cfg_w_raw) > CMP_W'(MAX_WIDTH)) begin
      width_cfg = WW'(MAX_WIDTH);
    end else begin
      width_cfg = WW'(cfg_w_raw);
    end
    height_cfg = (cfg_h_raw < CFG_H_W'(2)) ? CFG_H_W'(2) : cfg_h_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(RESET_W);
      height_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= width_cfg;
        REG_IMAGE_HEIGHT: height_r <= height_cfg;
        default: ;
      endcase
    end
  end

  // Raster position of the next step; past the frame end the steps flush results.
  assign height_ext = ROW_W'(height_r);
  assign accept     = in_tvalid && in_tready;
  assign frame_done = in_row_r >= height_ext;
  assign step       = accept && (!in_tuser || frame_done);
  assign step_emit  = frame_done || (in_row_r >= ROW_W'(2)) ||
                      ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
  assign step_last  = frame_done && (in_row_r == height_ext + ROW_W'(1));
  assign col_wrap   = (WW'(in_col_r) + WW'(1)) == width_r;

  assign bounds_nxt.up_ok    = prev_row_r != ROW_W'(1);
  assign bounds_nxt.down_ok  = prev_row_r != height_ext;
  assign bounds_nxt.left_ok  = prev_col_r != '0;
  assign bounds_nxt.right_ok = (WW'(prev_col_r) + WW'(1)) != width_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      prev_row_r <= '0;
      prev_col_r <= '0;
    end else if (step) begin
      if (step_last) begin
        in_row_r   <= '0;
        in_col_r   <= '0;
        prev_row_r <= '0;
        prev_col_r <= '0;
      end else begin
        prev_row_r <= in_row_r;
        prev_col_r <= in_col_r;
        in_col_r   <= col_wrap ? '0 : in_col_r + COL_W'(1);
        in_row_r   <= col_wrap ? in_row_r + ROW_W'(1) : in_row_r;
      end
    end
  end

  // Input register stage.
  assign out_free  = !out_valid_r || out_tready;
  assign a_go      = a_valid_r && (!a_emit_r || out_free);
  assign in_tready = !a_valid_r || a_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (step) begin
      a_valid_r <= 1'b1;
    end else if (a_go) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      a_emit_r   <= step_emit;
      a_last_r   <= step_last;
      a_gx_r     <= in_tdata[GRAD_W-1:0];
      a_gy_r     <= in_tdata[2*GRAD_W-1:GRAD_W];
      a_mag_r    <= in_tdata[2*GRAD_W+MAG_W-1:2*GRAD_W];
      a_col_r    <= in_col_r;
      a_bounds_r <= bounds_nxt;
    end
  end

  gnms_dir_bin u_dir_bin (
    .grad_x (a_gx_r),
    .grad_y (a_gy_r),
    .dir    (a_dir)
  );

  gnms_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk      (clk),
    .rd_en    (step),
    .rd_col   (in_col_r),
    .wr_en    (a_go),
    .wr_col   (a_col_r),
    .wr_mag   (a_mag_r),
    .wr_dir   (a_dir),
    .rd_upper (rd_upper),
    .rd_prev  (rd_prev),
    .rd_dir   (rd_dir)
  );

  assign new_col.top = rd_upper;
  assign new_col.mid = rd_prev;
  assign new_col.bot = a_mag_r;

  gnms_window u_window (
    .clk      (clk),
    .shift_en (a_go),
    .new_col  (new_col),
    .new_dir  (rd_dir),
    .bounds   (a_bounds_r),
    .kept_mag (kept_mag)
  );

  // Output register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_go && a_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_emit_r) begin
      out_mag_r  <= kept_mag;
      out_last_r <= a_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_mag_r);
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/gnms_checker.sv
// Port-level checker for the gradient non-maximum suppression block, with its bind.
`include "gradient_non_maximum_suppression_macros.svh"

module gnms_checker
  import gnms_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // A stalled result transaction keeps its payload.
  property p_out_hold;
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast);
  endproperty

  // Input is held back only by a result that cannot leave.
  property p_backpressure;
    !in_tready |-> out_tvalid && !out_tready;
  endproperty

  // Reset empties both register stages.
  property p_reset_empty;
    !rst_n |=> !out_tvalid && in_tready;
  endproperty

  `GNMS_ASSERT_ON(a_out_hold, p_out_hold, "stalled result changed")

  `GNMS_ASSERT_ON(a_backpressure, p_backpressure, "input stalled without an output stall")

  `GNMS_ASSERT_ALWAYS(a_reset_empty, p_reset_empty, "pipeline not empty after reset")

endmodule

bind gradient_non_maximum_suppression gnms_checker u_checker (.*);

>>> dv/tb_gradient_non_maximum_suppression.sv
// Self-checking testbench for the streaming 3x3 gradient non-maximum suppression block.
`timescale 1ns / 100ps

module tb_gradient_non_maximum_suppression;
  import gnms_pkg::*;

  localparam int unsigned RING_DEPTH = 2 * MAX_WIDTH_DEF + 4;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } nms_op_t;

  typedef struct {
    logic [MAG_W-1:0] kept;
    logic             last;
  } kept_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  gradient_non_maximum_suppression dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Predictor state.
  logic [MAG_W-1:0] mag_ring [RING_DEPTH];
  gnms_dir_t        dir_ring [RING_DEPTH];
  int unsigned      nms_width  = RESET_WIDTH;
  int unsigned      nms_height = RESET_HEIGHT;
  int unsigned      in_col     = 0;
  int unsigned      in_row     = 0;
  int unsigned      out_pos    = 0;

  kept_result_t pending_kept [$];

  int errors         = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int frames_done    = 0;
  int random_items   = 0;
  int burst_left     = 0;
  int hold_left      = 0;
  bit no_gaps        = 1'b0;

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_gradient_non_maximum_suppression: FAIL");
    $finish;
  end

  function automatic gnms_dir_t bin_direction(logic [GRAD_W-1:0] gx, logic [GRAD_W-1:0] gy);
    logic [GRAD_W-1:0] ax;
    logic [GRAD_W-1:0] ay;
    logic [63:0]       lhs;
    ax = gx[GRAD_W-1] ? GRAD_W'(~gx + 1'b1) : gx;
    ay = gy[GRAD_W-1] ? GRAD_W'(~gy + 1'b1) : gy;
    if (ax == '0) return (ay != '0) ? DIR_VERT : DIR_HORIZ;
    if (ay == '0) return DIR_HORIZ;
    lhs = 64'(ay) << FRAC_SHIFT;
    if (lhs > 64'(ax) * 64'(TAN_HIGH_Q32)) return DIR_VERT;
    if (lhs > 64'(ax) * 64'(TAN_LOW_Q32))
      return (gx[GRAD_W-1] == gy[GRAD_W-1]) ? DIR_DIAG : DIR_ANTI;
    return DIR_HORIZ;
  endfunction

  function automatic bit neighbour_blocks(int r, int c, logic [MAG_W-1:0] m);
    int unsigned idx;
    if (r < 0 || c < 0 || r >= int'(nms_height) || c >= int'(nms_width)) return 1'b0;
    idx = (int'(r) * nms_width + c) % RING_DEPTH;
    return m <= mag_ring[idx];
  endfunction

  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_pos = 0;
  endfunction

  function automatic void emit_kept(int unsigned total);
    int unsigned      p;
    int               r;
    int               c;
    int               dr;
    int               dc;
    logic [MAG_W-1:0] m;
    kept_result_t     res;
    p = out_pos;
    r = p / nms_width;
    c = p % nms_width;
    m = mag_ring[p % RING_DEPTH];
    case (dir_ring[p % RING_DEPTH])
      DIR_DIAG: begin
        dr = 1;
        dc = 1;
      end
      DIR_VERT: begin
        dr = 1;
        dc = 0;
      end
      DIR_ANTI: begin
        dr = -1;
        dc = 1;
      end
      default: begin
        dr = 0;
        dc = 1;
      end
    endcase
    if (neighbour_blocks(r - dr, c - dc, m) || neighbour_blocks(r + dr, c + dc, m)) m = '0;
    res.kept = m;
    res.last = (p + 1 == total);
    pending_kept.push_back(res);
    out_pos = p + 1;
    if (out_pos >= total) restart_frame();
  endfunction

  function automatic void predict_kept(nms_op_t op, logic [GRAD_W-1:0] gx,
                                       logic [GRAD_W-1:0] gy, logic [MAG_W-1:0] mag);
    int unsigned total;
    int unsigned pos;
    int unsigned slot;
    total = nms_width * nms_height;
    pos   = in_row * nms_width + in_col;
    if (op == OP_PIXEL && pos < total) begin
      slot = pos % RING_DEPTH;
      mag_ring[slot] = mag;
      dir_ring[slot] = bin_direction(gx, gy);
      in_col++;
      if (in_col >= nms_width) begin
        in_col = 0;
        in_row++;
      end
      pos++;
      if (pos - out_pos >= nms_width + 2) emit_kept(total);
    end else if (pos >= total && out_pos < total) begin
      emit_kept(total);
    end
  endfunction

  task automatic send_item(nms_op_t op, int gx, int gy, int mag);
    int gap;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                 : $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, mag[MAG_W-1:0], gy[GRAD_W-1:0], gx[GRAD_W-1:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_kept(op, gx[GRAD_W-1:0], gy[GRAD_W-1:0], mag[MAG_W-1:0]);
    items_sent++;
  endtask

  task automatic send_random_pixel();
    int gx;
    int gy;
    int mag;
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        gx = $urandom;
        gy = $urandom;
      end
      3: begin
        gx = 0;
        gy = $urandom_range(0, 1) ? int'($urandom_range(0, 6)) - 3 : 0;
      end
      default: begin
        gx = int'($urandom_range(0, 40)) - 20;
        gy = int'($urandom_range(0, 40)) - 20;
      end
    endcase
    case ($urandom_range(0, 2))
      0:       mag = $urandom;
      1:       mag = $urandom_range(0, 3);
      default: mag = $urandom_range(0, 1023);
    endcase
    send_item(OP_PIXEL, gx, gy, mag);
  endtask

  task automatic send_drain();
    send_item(OP_DRAIN, $urandom, $urandom, $urandom);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_kept.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(gnms_reg_t idx, int value);
    int unsigned v;
    wait_idle();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) begin
      v = value & 'h7FF;
      if (v < 2) v = 2;
      if (v > MAX_WIDTH_DEF) v = MAX_WIDTH_DEF;
      nms_width = v;
    end else begin
      v = value & 'hFFF;
      if (v < 2) v = 2;
      nms_height = v;
    end
    restart_frame();
  endtask

  // A whole frame of random pixels followed by the flush; noisy frames add ignored drains.
  task automatic run_frame(bit noisy);
    int unsigned n;
    int unsigned w;
    n = nms_width * nms_height;
    w = nms_width;
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_drain();
      send_random_pixel();
    end
    for (int unsigned i = 0; i <= w; i++) begin
      if ($urandom_range(0, 5) == 0) send_random_pixel();
      else send_drain();
    end
    if (noisy && $urandom_range(0, 1)) send_drain();
  endtask

  task automatic test_reset_geometry();
    repeat (645) send_random_pixel();
  endtask

  task automatic test_direction_bins();
    cfg_write(REG_IMAGE_WIDTH, 4);
    cfg_write(REG_IMAGE_HEIGHT, 3);
    send_item(OP_PIXEL, 0, 0, 32767);
    send_item(OP_PIXEL, 0, 5, 100);
    send_item(OP_PIXEL, 1020, 1020, 100);
    send_item(OP_PIXEL, -7, 0, 0);
    send_item(OP_PIXEL, -1024, 1023, 500);
    send_item(OP_PIXEL, 1023, -1024, 32767);
    send_item(OP_DRAIN, -1, -1, 32767);
    send_item(OP_PIXEL, 1000, 414, 200);
    send_item(OP_PIXEL, 1000, 415, 200);
    send_item(OP_PIXEL, 414, 1000, 300);
    send_item(OP_PIXEL, 415, 1000, 300);
    send_item(OP_PIXEL, -1, -1, 1);
    send_item(OP_PIXEL, 5, -2, 32767);
    send_drain();
    send_drain();
    send_item(OP_PIXEL, 3, 3, 77);
    send_drain();
    send_drain();
    send_drain();
  endtask

  task automatic test_size_extremes();
    cfg_write(REG_IMAGE_WIDTH, 0);
    cfg_write(REG_IMAGE_HEIGHT, 1);
    run_frame(1'b0);
    cfg_write(REG_IMAGE_WIDTH, 1);
    cfg_write(REG_IMAGE_HEIGHT, 0);
    run_frame(1'b1);
    cfg_write(REG_IMAGE_WIDTH, 'hFFF);
    cfg_write(REG_IMAGE_HEIGHT, 2);
    repeat (30) send_random_pixel();
    cfg_write(REG_IMAGE_WIDTH, 2);
    cfg_write(REG_IMAGE_HEIGHT, 4095);
    repeat (30) send_random_pixel();
  endtask

  task automatic test_ring_wrap();
    cfg_write(REG_IMAGE_WIDTH, 7);
    cfg_write(REG_IMAGE_HEIGHT, 6);
    run_frame(1'b1);
  endtask

  task automatic test_restart_mid_frame();
    cfg_write(REG_IMAGE_WIDTH, 5);
    cfg_write(REG_IMAGE_HEIGHT, 4);
    repeat (13) send_random_pixel();
    cfg_write(REG_IMAGE_HEIGHT, 4);
    run_frame(1'b1);
  endtask

  task automatic test_output_hold();
    cfg_write(REG_IMAGE_WIDTH, 8);
    cfg_write(REG_IMAGE_HEIGHT, 5);
    hold_left = 300;
    no_gaps   = 1'b1;
    run_frame(1'b0);
    no_gaps   = 1'b0;
  endtask

  task automatic test_random_frames();
    int w;
    int h;
    int cut;
    while (random_items < 50) begin
      w = $urandom_range(2, 9);
      h = $urandom_range(2, 6);
      if ($urandom_range(0, 1)) begin
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
      end else begin
        cfg_write(REG_IMAGE_HEIGHT, h);
        cfg_write(REG_IMAGE_WIDTH, w);
      end
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, w * h - 1);
        repeat (cut) send_random_pixel();
        random_items += cut;
      end else begin
        run_frame(1'b1);
        random_items += w * h;
      end
    end
  endtask

  // The receiver switches between stall patterns; a requested hold-off overrides them.
  initial begin : receiver
    int mode;
    int mode_left;
    int phase;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1);
          2:       out_tready <= ($urandom_range(0, 9) != 0);
          default: out_tready <= (phase % 4 != 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    kept_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_kept.size() == 0) begin
        $display("%0t: unexpected result kept_magnitude=%0d frame_last=%0b",
                 $time, out_tdata[MAG_W-1:0], out_tlast);
        errors++;
      end else begin
        want = pending_kept.pop_front();
        if (out_tdata[MAG_W-1:0] !== want.kept) begin
          $display("%0t: kept_magnitude expected %0d actual %0d",
                   $time, want.kept, out_tdata[MAG_W-1:0]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: frame_last expected %0b actual %0b", $time, want.last, out_tlast);
          errors++;
        end
        results_seen++;
        if (want.last) frames_done++;
      end
    end
  end

  initial begin : main_sequence
    for (int i = 0; i < RING_DEPTH; i++) begin
      mag_ring[i] = '0;
      dir_ring[i] = DIR_HORIZ;
    end
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_PIXEL;
    cfg_we    <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_geometry();
    test_direction_bins();
    test_size_extremes();
    test_ring_wrap();
    test_restart_mid_frame();
    test_output_hold();
    test_random_frames();
    wait_idle();
    repeat (20) @(posedge clk);
    $display("Run covered %0d input transactions, %0d results and %0d complete frames,",
             items_sent, results_seen, frames_done);
    $display("with the reset size, every direction bin, clamped sizes and a long hold-off.");
    if (errors == 0) begin
      $display("tb_gradient_non_maximum_suppression: PASS");
    end else begin
      $display("tb_gradient_non_maximum_suppression: FAIL");
    end
    $finish;
  end

endmodule
